FILE: rtl/heightfield_hillshade_defines.svh
// ----------------------------------------------------------------------------
// Hillshade assertion macros
// Concurrent assertion forms used by the hillshade entry queue.
// ----------------------------------------------------------------------------
`ifndef HEIGHTFIELD_HILLSHADE_DEFINES_SVH
`define HEIGHTFIELD_HILLSHADE_DEFINES_SVH

// The condition must never hold outside reset.
`define HH_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When pre holds, post must hold in the next cycle.
`define HH_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/hh_pkg.sv
// ----------------------------------------------------------------------------
// Hillshade package
// Sizes, the queue entry type, color constants and the divide-by-5 helper.
// ----------------------------------------------------------------------------
package hh_pkg;

  localparam int GRID_SIZE = 256;
  localparam int CW        = $clog2(GRID_SIZE);
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  // One pixel to shade: its center sample and four neighbors.
  typedef struct packed {
    logic [15:0]   center;
    logic [15:0]   left;
    logic [15:0]   right;
    logic [15:0]   up;
    logic [15:0]   down;
    logic [CW-1:0] col;
    logic [CW-1:0] row;
    logic          last;
  } ent_t;

  localparam logic [7:0] LO_R = 8'd18;
  localparam logic [7:0] LO_G = 8'd34;
  localparam logic [7:0] LO_B = 8'd26;
  localparam logic [7:0] SPAN_R = 8'd114;
  localparam logic [7:0] SPAN_G = 8'd134;
  localparam logic [7:0] SPAN_B = 8'd90;

  // Exact floor(v / 5) for v below 1024.
  function automatic logic [7:0] div5(input logic [9:0] v);
    logic [17:0] p;
    p = {8'd0, v} * 18'd205;
    return p[17:10];
  endfunction

endpackage

FILE: rtl/heightfield_hillshade.sv
// ----------------------------------------------------------------------------
// Heightfield hillshade
// Streams a square heightfield in raster order and emits shaded RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, height) takes one height sample per
// transaction, row by row. The block answers each sample with zero to three
// pixels on the output channel (out_valid, out_stall, red, green, blue,
// column, row, final_pixel); row 0 produces none, and the last sample of the
// image flushes the bottom row and raises final_pixel.
// The front end takes no new sample until it has passed its accept state, two
// line-store reads, one write and three pixel slots. The back end shades one
// pixel at a time: a pop state, four setup states, the 32-step square root,
// the 48-step divider and three finish states, the last waiting on out_stall.
// A four-entry queue sits between them, so samples keep flowing while pixels
// are shaded; once it fills, in_stall stays high.
// The output is a register: a stalled pixel holds while the next is computed.
// slope_scale is to be written through cfg_valid/cfg_ready only while the
// block is idle; the block does not enforce this. Synchronous reset returns
// to column 0, row 0 and slope_scale 12.0; the line stores are not cleared.
// ----------------------------------------------------------------------------
module heightfield_hillshade (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] slope_scale,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] height,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  column,
  output logic [7:0]  row,
  output logic        final_pixel
);
  import hh_pkg::*;

  logic [23:0] slope;
  logic        push, full, pop, empty;
  ent_t        wdata, rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slope <= 24'd49152;
    end else if (cfg_valid && cfg_ready) begin
      slope <= slope_scale;
    end
  end

  hh_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .height   (height),
    .push     (push),
    .wdata    (wdata),
    .full     (full)
  );

  hh_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wdata),
    .full  (full),
    .pop   (pop),
    .rdata (rdata),
    .empty (empty)
  );

  hh_back u_back (
    .clk         (clk),
    .rst         (rst),
    .slope       (slope),
    .empty       (empty),
    .rdata       (rdata),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .column      (column),
    .row         (row),
    .final_pixel (final_pixel)
  );

endmodule

FILE: rtl/hh_fifo.sv
// ----------------------------------------------------------------------------
// Hillshade entry queue
// Short queue between the line-store front end and the shading back end.
// ----------------------------------------------------------------------------
`include "heightfield_hillshade_defines.svh"

module hh_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  hh_pkg::ent_t wdata,
  output logic         full,
  input  logic         pop,
  output hh_pkg::ent_t rdata,
  output logic         empty
);
  import hh_pkg::*;

  ent_t         mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign full  = (count == (QAW+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `HH_ASSERT_NEVER(a_no_overflow, push && full, "push into a full queue")
  `HH_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from an empty queue")
  `HH_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after a push")

endmodule

FILE: rtl/hh_front.sv
// ----------------------------------------------------------------------------
// Hillshade front end
// Tracks the raster position, keeps two line stores and gathers neighbors.
// ----------------------------------------------------------------------------
module hh_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [15:0]  height,
  output logic         push,
  output hh_pkg::ent_t wdata,
  input  logic         full
);
  import hh_pkg::*;

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_RD0  = 3'd1;
  localparam logic [2:0] F_RD1  = 3'd2;
  localparam logic [2:0] F_WR   = 3'd3;
  localparam logic [2:0] F_E1   = 3'd4;
  localparam logic [2:0] F_E2   = 3'd5;
  localparam logic [2:0] F_E3   = 3'd6;

  localparam logic [CW-1:0] LAST = CW'(GRID_SIZE - 1);

  logic [15:0] above_mem [GRID_SIZE];
  logic [15:0] mid_mem   [GRID_SIZE];

  logic [2:0]    state;
  logic [CW-1:0] col;
  logic [CW-1:0] row;
  logic [15:0]   h_q, a_q, m_q, r_q;
  logic [15:0]   prev_m, prev_h, prev2_h;
  logic [CW-1:0] right_addr;
  logic          need1, need2, need3;
  ent_t          ent1, ent2, ent3;

  assign in_stall   = (state != F_IDLE);
  assign right_addr = (col == LAST) ? '0 : col + 1'b1;

  assign need1 = (row != '0);
  assign need2 = (row == LAST) && (col != '0);
  assign need3 = (row == LAST) && (col == LAST);

  always_comb begin
    ent1.center = m_q;
    ent1.left   = (col != '0) ? prev_m : m_q;
    ent1.right  = (col != LAST) ? r_q : m_q;
    ent1.up     = (row > CW'(1)) ? a_q : m_q;
    ent1.down   = h_q;
    ent1.col    = col;
    ent1.row    = row - 1'b1;
    ent1.last   = 1'b0;

    ent2.center = prev_h;
    ent2.left   = (col > CW'(1)) ? prev2_h : prev_h;
    ent2.right  = h_q;
    ent2.up     = prev_m;
    ent2.down   = prev_h;
    ent2.col    = col - 1'b1;
    ent2.row    = row;
    ent2.last   = 1'b0;

    ent3.center = h_q;
    ent3.left   = prev_h;
    ent3.right  = h_q;
    ent3.up     = m_q;
    ent3.down   = h_q;
    ent3.col    = col;
    ent3.row    = row;
    ent3.last   = 1'b1;
  end

  always_comb begin
    push  = 1'b0;
    wdata = ent1;
    unique case (state)
      F_E1: begin
        push = need1 && !full;
      end
      F_E2: begin
        push  = need2 && !full;
        wdata = ent2;
      end
      F_E3: begin
        push  = need3 && !full;
        wdata = ent3;
      end
      default: ;
    endcase
  end

  // Line stores: one read port each, registered read data.
  always_ff @(posedge clk) begin
    if (state == F_RD0) begin
      a_q <= above_mem[col];
      m_q <= mid_mem[col];
    end
    if (state == F_RD1) begin
      r_q <= mid_mem[right_addr];
    end
    if (state == F_WR) begin
      above_mem[col] <= m_q;
      mid_mem[col]   <= h_q;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) h_q <= height;
    if (state == F_E3 && (!need3 || !full)) begin
      prev_m  <= m_q;
      prev2_h <= prev_h;
      prev_h  <= h_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      col   <= '0;
      row   <= '0;
    end else begin
      unique case (state)
        F_IDLE: if (in_valid) state <= F_RD0;
        F_RD0:  state <= F_RD1;
        F_RD1:  state <= F_WR;
        F_WR:   state <= F_E1;
        F_E1:   if (!need1 || !full) state <= F_E2;
        F_E2:   if (!need2 || !full) state <= F_E3;
        F_E3: begin
          if (!need3 || !full) begin
            state <= F_IDLE;
            if (col == LAST) begin
              col <= '0;
              row <= (row == LAST) ? '0 : row + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/hh_back.sv
// ----------------------------------------------------------------------------
// Hillshade back end
// Shades one queued pixel: gradients, normal length, lighting and color mix.
// ----------------------------------------------------------------------------
module hh_back (
  input  logic         clk,
  input  logic         rst,
  input  logic [23:0]  slope,
  input  logic         empty,
  input  hh_pkg::ent_t rdata,
  output logic         pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   red,
  output logic [7:0]   green,
  output logic [7:0]   blue,
  output logic [7:0]   column,
  output logic [7:0]   row,
  output logic         final_pixel
);
  import hh_pkg::*;

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_MUL   = 4'd1;
  localparam logic [3:0] B_SQ    = 4'd2;
  localparam logic [3:0] B_SUM   = 4'd3;
  localparam logic [3:0] B_SCALE = 4'd4;
  localparam logic [3:0] B_SQRT  = 4'd5;
  localparam logic [3:0] B_DIV   = 4'd6;
  localparam logic [3:0] B_T     = 4'd7;
  localparam logic [3:0] B_CH    = 4'd8;
  localparam logic [3:0] B_OUT   = 4'd9;

  localparam logic [20:0] T_CAP = 21'd1310720;

  logic [3:0]  state;
  ent_t        e_q;
  logic [27:0] dxm, dzm;
  logic        dxn, dzn;
  logic [55:0] sqx, sqz;
  logic [63:0] sum, rad;
  logic [33:0] acc;
  logic [31:0] root;
  logic [34:0] srem;
  logic [47:0] dvd, quo;
  logic [32:0] drem;
  logic [5:0]  step;
  logic [20:0] t_q;
  logic [9:0]  vr, vg, vb;

  logic [16:0] ddx, ddz;
  logic [15:0] adx, adz;
  logic [39:0] px, pz;
  logic [28:0] dxs, dzs;
  logic [33:0] a_val;
  logic [34:0] s_shift, s_trial;
  logic [32:0] d_shift;
  logic [16:0] lit;
  logic [21:0] t_sum;
  logic [28:0] cr, cg, cb;
  logic        out_free;

  assign pop      = (state == B_IDLE) && !empty;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    ddx = {1'b0, e_q.right} - {1'b0, e_q.left};
    ddz = {1'b0, e_q.down} - {1'b0, e_q.up};
    adx = ddx[16] ? 16'(-ddx) : ddx[15:0];
    adz = ddz[16] ? 16'(-ddz) : ddz[15:0];
    px  = {24'd0, adx} * {16'd0, slope};
    pz  = {24'd0, adz} * {16'd0, slope};
    dxs = dxn ? -{1'b0, dxm} : {1'b0, dxm};
    dzs = dzn ? -{1'b0, dzm} : {1'b0, dzm};
    a_val = 34'(signed'({{5{dxs[28]}}, dxs}) * 34'sd6)
          + 34'(signed'({{5{dzs[28]}}, dzs}) * 34'sd4) + 34'd458752;
    s_shift = {srem[32:0], rad[63:62]};
    s_trial = {1'b0, root, 2'b01};
    d_shift = {drem[31:0], dvd[47]};
    if (acc[33] || acc == '0) lit = '0;
    else if (quo > 48'd65536) lit = 17'd65536;
    else lit = quo[16:0];
    t_sum = 22'd327680 + 22'({lit, 3'b000} + {lit, 2'b00} + {4'd0, lit})
          + 22'({2'd0, e_q.center, 2'b00} + {4'd0, e_q.center});
    cr = {8'd0, t_q} * {21'd0, SPAN_R};
    cg = {8'd0, t_q} * {21'd0, SPAN_G};
    cb = {8'd0, t_q} * {21'd0, SPAN_B};
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: if (!empty) e_q <= rdata;
      B_MUL: begin
        dxm <= px[39:12];
        dzm <= pz[39:12];
        dxn <= ddx[16];
        dzn <= ddz[16];
      end
      B_SQ: begin
        sqx <= dxm * dxm;
        sqz <= dzm * dzm;
        acc <= a_val;
      end
      B_SUM: sum <= {8'd0, sqx} + {8'd0, sqz} + 64'h1_0000_0000;
      B_SCALE: begin
        rad  <= (sum << 6) + (sum << 5) + (sum << 2) + sum;
        root <= '0;
        srem <= '0;
      end
      B_SQRT: begin
        // One result bit per cycle, two radicand bits consumed.
        rad <= {rad[61:0], 2'b00};
        if (s_shift >= s_trial) begin
          srem <= s_shift - s_trial;
          root <= {root[30:0], 1'b1};
        end else begin
          srem <= s_shift;
          root <= {root[30:0], 1'b0};
        end
        if (step == 6'd31) begin
          dvd  <= {acc[31:0], 16'd0};
          drem <= '0;
          quo  <= '0;
        end
      end
      B_DIV: begin
        dvd <= {dvd[46:0], 1'b0};
        if (d_shift >= {1'b0, root}) begin
          drem <= d_shift - {1'b0, root};
          quo  <= {quo[46:0], 1'b1};
        end else begin
          drem <= d_shift;
          quo  <= {quo[46:0], 1'b0};
        end
      end
      B_T: t_q <= (t_sum > {1'b0, T_CAP}) ? T_CAP : t_sum[20:0];
      B_CH: begin
        vr <= cr[27:18];
        vg <= cg[27:18];
        vb <= cb[27:18];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == B_OUT && out_free) begin
      red         <= LO_R + div5(vr);
      green       <= LO_G + div5(vg);
      blue        <= LO_B + div5(vb);
      column      <= 8'(e_q.col);
      row         <= 8'(e_q.row);
      final_pixel <= e_q.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == B_OUT && out_free) out_valid <= 1'b1;
      else if (!out_stall)            out_valid <= 1'b0;
      unique case (state)
        B_IDLE:  if (!empty) state <= B_MUL;
        B_MUL:   state <= B_SQ;
        B_SQ:    state <= B_SUM;
        B_SUM:   state <= B_SCALE;
        B_SCALE: begin
          state <= B_SQRT;
          step  <= '0;
        end
        B_SQRT: begin
          step <= step + 1'b1;
          if (step == 6'd31) begin
            state <= B_DIV;
            step  <= '0;
          end
        end
        B_DIV: begin
          step <= step + 1'b1;
          if (step == 6'd47) state <= B_T;
        end
        B_T:     state <= B_CH;
        B_CH:    state <= B_OUT;
        B_OUT:   if (out_free) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/tb_heightfield_hillshade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Heightfield hillshade testbench
// Streams the first row and part of the second row of a heightfield through
// the block. A behavioral shading model predicts each pixel, and the output
// transactions are checked against it in order. slope_scale changes between
// short segments of the second row while the block is idle. Both channels
// idle at random, and the output holds off once for a long stretch so that
// the block fills up.
// ----------------------------------------------------------------------------
module tb_heightfield_hillshade;
  import hh_pkg::*;

  localparam int SEGMENTS   = 5;
  localparam int SEG_LEN    = 16;
  localparam int DRAIN_WAIT = 400;
  localparam int CYCLE_CAP  = 1500000;
  localparam longint unsigned ONE_Q16 = 65536;
  localparam longint unsigned T_FULL  = 20 * 65536;

  typedef struct {
    logic [7:0] r, g, b, col, row;
    logic       last;
  } pixel_t;

  logic        clk, rst;
  logic        cfg_valid, cfg_ready;
  logic [23:0] slope_scale;
  logic        in_valid, in_stall;
  logic [15:0] height;
  logic        out_valid, out_stall;
  logic [7:0]  red, green, blue, column, row;
  logic        final_pixel;

  heightfield_hillshade dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .slope_scale(slope_scale),
    .in_valid(in_valid), .in_stall(in_stall), .height(height),
    .out_valid(out_valid), .out_stall(out_stall),
    .red(red), .green(green), .blue(blue),
    .column(column), .row(row), .final_pixel(final_pixel)
  );

  // Shading model state.
  logic [15:0] upper_line [GRID_SIZE];
  logic [15:0] middle_line [GRID_SIZE];
  int          pos_x, pos_z;
  logic [23:0] model_scale;

  pixel_t pending_pixels[$];
  int     errors;
  int     pixels_seen;
  longint cycles;

  // Directed opening of row 0: extremes and sharp steps.
  logic [15:0] opening_heights [20] = '{
    16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF,
    16'h5555, 16'hAAAA, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFF00,
    16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles", cycles);
      $display("heightfield_hillshade test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root, probe, rem;
    rem = v;
    root = '0;
    probe = 64'h1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return root;
  endfunction

  // Height difference times slope, in units of 2^-16, truncated toward zero.
  function automatic longint slope_term(input int unsigned hi_s, input int unsigned lo_s);
    longint unsigned mag;
    mag = (hi_s >= lo_s) ? hi_s - lo_s : lo_s - hi_s;
    mag = (mag * model_scale) >> 12;
    return (hi_s < lo_s) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic pixel_t shade_pixel(input int unsigned centre, left, right, up, down,
                                         input int col, input int rw, input logic last);
    longint dx, dz, a;
    longint unsigned ux, uz, lit, t;
    pixel_t p;
    dx = slope_term(right, left);
    dz = slope_term(down, up);
    a = 6 * dx + 4 * dz + 7 * longint'(ONE_Q16);
    lit = 0;
    if (a > 0) begin
      ux = (dx < 0) ? -dx : dx;
      uz = (dz < 0) ? -dz : dz;
      lit = (unsigned'(a) << 16) / int_sqrt(101 * (ux * ux + uz * uz + (64'h1 << 32)));
      if (lit > ONE_Q16) lit = ONE_Q16;
    end
    t = 5 * ONE_Q16 + 13 * lit + 5 * 64'(centre);
    if (t > T_FULL) t = T_FULL;
    p.r = 8'(LO_R + (SPAN_R * t) / T_FULL);
    p.g = 8'(LO_G + (SPAN_G * t) / T_FULL);
    p.b = 8'(LO_B + (SPAN_B * t) / T_FULL);
    p.col = 8'(col);
    p.row = 8'(rw);
    p.last = last;
    return p;
  endfunction

  // Updates the line stores and queues the pixels that this sample completes.
  task automatic accept_height(input logic [15:0] h);
    int unsigned a, m, c, lf, rt, up;
    int x, z;
    x = pos_x;
    z = pos_z;
    a = upper_line[x];
    m = middle_line[x];
    upper_line[x] = m;
    middle_line[x] = h;
    if (z >= 1) begin
      lf = (x > 0) ? upper_line[x-1] : m;
      rt = (x + 1 < GRID_SIZE) ? middle_line[x+1] : m;
      up = (z >= 2) ? a : m;
      pending_pixels.push_back(shade_pixel(m, lf, rt, up, h, x, z - 1, 1'b0));
    end
    if (z == GRID_SIZE - 1 && x >= 1) begin
      c = middle_line[x-1];
      lf = (x >= 2) ? middle_line[x-2] : c;
      pending_pixels.push_back(shade_pixel(c, lf, h, upper_line[x-1], c, x - 1, z, 1'b0));
    end
    if (z == GRID_SIZE - 1 && x == GRID_SIZE - 1)
      pending_pixels.push_back(shade_pixel(h, middle_line[GRID_SIZE-2], h,
                                           upper_line[GRID_SIZE-1], h, x, z, 1'b1));
    pos_x++;
    if (pos_x >= GRID_SIZE) begin
      pos_x = 0;
      pos_z = (pos_z + 1 >= GRID_SIZE) ? 0 : pos_z + 1;
    end
  endtask

  function automatic int gap_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The directed table first, then extremes, random values and small steps.
  function automatic logic [15:0] pick_height(input int idx, input logic [15:0] prev_h);
    int roll;
    if (idx < 20) return opening_heights[idx];
    roll = $urandom_range(0, 99);
    if (roll < 15) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    if (roll < 45) return 16'($urandom);
    return prev_h + 16'($urandom_range(0, 2047)) - 16'd1024;
  endfunction

  task automatic send_height(input logic [15:0] h, input bit burst);
    int gap;
    gap = burst ? 0 : gap_length();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    height <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    accept_height(h);
  endtask

  task automatic write_slope(input logic [23:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    slope_scale <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_scale = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Output side: random stalls, one long hold-off early in the second row.
  initial begin
    bit held;
    int hold;
    held = 0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && pixels_seen >= 2) begin
        held = 1;
        out_stall <= 1'b1;
        for (hold = 0; hold < 800; hold++) @(negedge clk);
      end
      hold = gap_length();
      if (hold == 0 || $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pixel_t e;
    if (!rst && out_valid && !out_stall) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected pixel col %0d row %0d", column, row));
      end else begin
        e = pending_pixels.pop_front();
        if (red !== e.r)
          report_mismatch($sformatf("red %0d, want %0d at (%0d,%0d)", red, e.r, e.col, e.row));
        if (green !== e.g)
          report_mismatch($sformatf("green %0d, want %0d at (%0d,%0d)", green, e.g, e.col,
                                    e.row));
        if (blue !== e.b)
          report_mismatch($sformatf("blue %0d, want %0d at (%0d,%0d)", blue, e.b, e.col, e.row));
        if (column !== e.col)
          report_mismatch($sformatf("column %0d, want %0d", column, e.col));
        if (row !== e.row)
          report_mismatch($sformatf("row %0d, want %0d", row, e.row));
        if (final_pixel !== e.last)
          report_mismatch($sformatf("final_pixel %0b, want %0b", final_pixel, e.last));
      end
    end
  end

  initial begin
    logic [23:0] slopes [SEGMENTS];
    logic [15:0] h, prev;
    bit burst;
    int i;
    errors = 0;
    pixels_seen = 0;
    cycles = 0;
    pos_x = 0;
    pos_z = 0;
    model_scale = 24'd49152;
    for (i = 0; i < GRID_SIZE; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    rst = 1'b1;
    cfg_valid = 1'b0;
    slope_scale = '0;
    in_valid = 1'b0;
    height = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    slopes = '{24'd4096, 24'hFFFFFF, 24'd0, 24'($urandom_range(1, 24'hFFFFFE)), 24'd49152};
    prev = 16'h8000;
    burst = 0;
    // Row 0 only fills the line stores; each segment of row 1 gets its own slope.
    for (i = 0; i < GRID_SIZE + SEGMENTS * SEG_LEN; i++) begin
      if (i >= GRID_SIZE && (i - GRID_SIZE) % SEG_LEN == 0) begin
        wait_idle();
        write_slope(slopes[(i - GRID_SIZE) / SEG_LEN]);
      end
      if (i % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      h = pick_height(i, prev);
      prev = h;
      send_height(h, burst);
    end
    wait_idle();
    if (pending_pixels.size() != 0)
      report_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
    if (errors == 0) begin
      $display("heightfield_hillshade test passed");
    end else begin
      $display("heightfield_hillshade test failed");
    end
    $finish;
  end

endmodule
